>>> src/atpr_pkg.sv
// Shared constants and types for the tilt angle unit.
// No dependencies; used by atpr_lane and accel_tilt_pitch_roll_unit.
package atpr_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int ACC_FRAC            = 20;
   localparam int SQRT_STEPS          = 24;
   localparam int CORDIC_STEPS        = 24;
   localparam int SAMPLE_W            = 12;
   localparam int DATA_W              = 28;
   localparam int MAG_LIMIT           = 32767;
   // square stage + root stages + rotation stages + output stage
   localparam int LANE_LATENCY        = 1 + SQRT_STEPS + CORDIC_STEPS + 1;

   // atan(2^-i) in degrees * 2^20
   localparam logic [26:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
      27'd1876857,  27'd938658,   27'd469357,   27'd234682,  27'd117342,
      27'd58671,    27'd29335,    27'd14668,    27'd7334,    27'd3667,
      27'd1833,     27'd917,      27'd458,      27'd229,     27'd115,
      27'd57,       27'd29,       27'd14,       27'd7
   };

   typedef struct packed {
      logic        a_neg;
      logic        a_zero;
      logic        s_zero;
      logic [11:0] a_mag;
   } tag_type;

endpackage

>>> src/atpr_lane.sv
// One angle lane: square sum, pipelined bitwise square root, pipelined
// vectoring CORDIC and output rounding. Depends on atpr_pkg.
module atpr_lane #(
   parameter int ANGLE_FRAC_BITS = atpr_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [11:0]   a,
   input  logic signed [11:0]   b,
   input  logic signed [11:0]   c,
   output logic signed [15:0]   angle,
   output logic                 undef
);

   localparam int SH   = atpr_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int NS   = atpr_pkg::SQRT_STEPS;
   localparam int NC   = atpr_pkg::CORDIC_STEPS;
   localparam int DW   = atpr_pkg::DATA_W;
   localparam logic [27:0] HALF = 28'(1) << (SH - 1);
   localparam logic [19:0] FULL = 20'(90) << ANGLE_FRAC_BITS;
   localparam logic [19:0] LIM  = 20'(atpr_pkg::MAG_LIMIT);

   atpr_pkg::tag_type tag_ff [0:NS+NC];
   logic [27:0]        rem_ff  [0:NS];
   logic [23:0]        root_ff [0:NS];
   logic [47:0]        v_ff    [0:NS];

   logic signed [DW-1:0] cx [0:NC];
   logic signed [DW-1:0] cy [0:NC];
   logic signed [DW-1:0] cz [0:NC];

   logic signed [15:0] angle_ff;
   logic               undef_ff;

   // stage 0: squares and flags
   logic signed [23:0] bb, cc;
   logic [23:0]        s;
   logic signed [12:0] ae;
   atpr_pkg::tag_type  tag_in;

   always_comb begin
      bb = b * b;
      cc = c * c;
      s  = 24'(bb) + 24'(cc);
      ae = 13'(a);
      tag_in.a_neg  = a[11];
      tag_in.a_zero = (a == 12'sd0);
      tag_in.s_zero = (s == 24'd0);
      tag_in.a_mag  = a[11] ? 12'(-ae) : 12'(ae);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0]  <= tag_in;
         rem_ff[0]  <= 28'd0;
         root_ff[0] <= 24'd0;
         v_ff[0]    <= {s, 24'd0};
      end
   end

   // root: one result bit per stage
   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [27:0] rem_sh, trial;
      always_comb begin
         rem_sh = {rem_ff[k][25:0], v_ff[k][47:46]};
         trial  = {2'b00, root_ff[k], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k+1] <= tag_ff[k];
            v_ff[k+1]   <= {v_ff[k][45:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff[k+1]  <= rem_sh - trial;
               root_ff[k+1] <= {root_ff[k][22:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= rem_sh;
               root_ff[k+1] <= {root_ff[k][22:0], 1'b0};
            end
         end
      end
   end

   assign cx[0] = DW'({4'b0000, root_ff[NS]});
   assign cy[0] = DW'({4'b0000, tag_ff[NS].a_mag, 12'd0});
   assign cz[0] = '0;

   // rotations: one micro-rotation per stage
   for (genvar i = 0; i < NC; i++) begin : g_cordic
      logic signed [DW-1:0] xs, ys, yn;
      logic signed [DW-1:0] x_ff, y_ff, z_ff;
      always_comb begin
         xs = cx[i] >>> i;
         yn = -cy[i];
         ys = cy[i][DW-1] ? -(yn >>> i) : (cy[i] >>> i);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[NS+1+i] <= tag_ff[NS+i];
            if (!cy[i][DW-1]) begin
               x_ff <= cx[i] + ys;
               y_ff <= cy[i] - xs;
               z_ff <= cz[i] + DW'(atpr_pkg::ATAN_TAB[i]);
            end else begin
               x_ff <= cx[i] - ys;
               y_ff <= cy[i] + xs;
               z_ff <= cz[i] - DW'(atpr_pkg::ATAN_TAB[i]);
            end
         end
      end
      assign cx[i+1] = x_ff;
      assign cy[i+1] = y_ff;
      assign cz[i+1] = z_ff;
   end

   // output: round, limit, sign, special cases
   atpr_pkg::tag_type tf;
   logic [27:0] zc, zr;
   logic [19:0] mag;
   logic [16:0] mag_s;
   always_comb begin
      tf  = tag_ff[NS+NC];
      zc  = cz[NC][DW-1] ? 28'd0 : 28'(cz[NC]);
      zr  = (zc + HALF) >> SH;
      mag = zr[19:0];
      if (tf.s_zero || mag > FULL) mag = FULL;
      if (mag > LIM) mag = LIM;
      mag_s = {1'b0, mag[15:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         undef_ff <= tf.a_zero && tf.s_zero;
         if (tf.a_zero)      angle_ff <= 16'sd0;
         else if (tf.a_neg)  angle_ff <= 16'(-$signed(mag_s));
         else                angle_ff <= 16'(mag_s);
      end
   end

   assign angle = angle_ff;
   assign undef = undef_ff;

endmodule

>>> src/accel_tilt_pitch_roll_unit.sv
// Top level of the accelerometer tilt unit: two angle lanes and merge.
// Depends on atpr_pkg and atpr_lane.
//
// Each transaction carries one accelerometer reading (three left-justified
// 16-bit axis words); each gives exactly one result transaction with pitch
// and roll in signed degrees scaled by 2^ANGLE_FRAC_BITS, plus a flag for a
// zero-over-zero angle. Two identical lanes run side by side, one for pitch
// and one for roll, each a fully pipelined chain of a square-sum stage,
// 24 square-root stages (one root bit each), 24 CORDIC rotation stages and
// an output stage. A new reading is taken every cycle while the pipe is not
// held. The whole pipe holds while a finished result is not taken, so
// throughput is one transaction per cycle when rsp_tready is high.
module accel_tilt_pitch_roll_unit #(
   parameter int ANGLE_FRAC_BITS = atpr_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_word[15:0], y_word[31:16], z_word[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // pitch[15:0], roll[31:16], undef[32], zero
);

   localparam int L = atpr_pkg::LANE_LATENCY;

   logic [L-1:0] vld_ff, vld_in;
   logic         en;

   // pipe advances unless the output slot is full and not being taken
   assign en         = !vld_ff[L-1] || rsp_tready;
   assign req_tready = en;

   // samples: arithmetic shift by four leaves the top 12 bits
   logic signed [11:0] xs, ys, zs;
   assign xs = req_tdata[15:4];
   assign ys = req_tdata[31:20];
   assign zs = req_tdata[47:36];

   always_comb begin
      vld_in = {vld_ff[L-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   logic signed [15:0] pitch, roll;
   logic               pitch_undef, roll_undef;

   atpr_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock (clock), .en (en), .a (xs), .b (ys), .c (zs),
      .angle (pitch), .undef (pitch_undef)
   );

   atpr_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock (clock), .en (en), .a (ys), .b (xs), .c (zs),
      .angle (roll), .undef (roll_undef)
   );

   // merge: flag is raised if either lane met zero over zero
   assign rsp_tvalid = vld_ff[L-1];
   assign rsp_tdata  = {7'd0, pitch_undef | roll_undef, roll, pitch};

endmodule

>>> bench/tb_accel_tilt_pitch_roll_unit.sv
// Self-checking bench for accel_tilt_pitch_roll_unit: streamed readings,
// bit-exact prediction of pitch, roll and flag. Depends on atpr_pkg.
`timescale 1ns / 100ps

module tb_accel_tilt_pitch_roll_unit;

   localparam int FRAC = atpr_pkg::ANGLE_FRAC_BITS_DEF;

   typedef struct packed {
      logic [15:0] pitch;
      logic [15:0] roll;
      logic        undef;
   } angles_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   logic [47:0] readings_q[$];
   angles_type  angles_q[$];
   int          fail_count = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   int unsigned stall_phase = 0;

   accel_tilt_pitch_roll_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // one tilt angle: atan(a / sqrt(b^2 + c^2)), vectoring CORDIC
   function automatic longint tilt(longint a, longint b, longint c, inout logic undef);
      longint s, mag, x, y, z, xs, ys;
      longint full;
      full = longint'(90) << FRAC;
      s = b * b + c * c;
      if (a == 0) begin
         if (s == 0) undef = 1'b1;
         return 0;
      end
      if (s == 0) begin
         mag = full;
      end else begin
         x = longint'(int_sqrt(longint'(s) << 24));
         y = (a < 0 ? -a : a) * 4096;
         z = 0;
         for (int i = 0; i < atpr_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = (y < 0) ? -((-y) >>> i) : (y >>> i);
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(atpr_pkg::ATAN_TAB[i]);
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(atpr_pkg::ATAN_TAB[i]);
            end
         end
         if (z < 0) z = 0;
         mag = (z + (longint'(1) << (atpr_pkg::ACC_FRAC - FRAC - 1)))
               >>> (atpr_pkg::ACC_FRAC - FRAC);
         if (mag > full) mag = full;
      end
      if (mag > atpr_pkg::MAG_LIMIT) mag = atpr_pkg::MAG_LIMIT;
      return a < 0 ? -mag : mag;
   endfunction

   function automatic angles_type predict_angles(logic [47:0] d);
      angles_type r;
      longint sx, sy, sz;
      logic u;
      sx = longint'($signed(d[15:4]));
      sy = longint'($signed(d[31:20]));
      sz = longint'($signed(d[47:36]));
      u = 1'b0;
      r.pitch = 16'(tilt(sx, sy, sz, u));
      r.roll  = 16'(tilt(sy, sx, sz, u));
      r.undef = u;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // driver: bursts of transactions with random gaps between them
   always @(posedge clock) begin
      logic next_valid;
      logic [47:0] next_data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) angles_q.push_back(predict_angles(req_tdata));
         next_valid = req_tvalid && !req_tready;
         next_data = req_tdata;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (readings_q.size() > 0) begin
               next_valid = 1'b1;
               next_data = readings_q.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end
            end
         end
         req_tvalid <= next_valid;
         req_tdata <= next_data;
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (angles_q.size() == 0) begin
            $display("unexpected result transaction at %0t", $time);
            fail_count++;
         end else begin
            want = angles_q.pop_front();
            if (rsp_tdata[15:0] !== want.pitch)
               report_mismatch("pitch", rsp_tdata[15:0], want.pitch);
            if (rsp_tdata[31:16] !== want.roll)
               report_mismatch("roll", rsp_tdata[31:16], want.roll);
            if (rsp_tdata[32] !== want.undef)
               report_mismatch("flag", 16'(rsp_tdata[32]), 16'(want.undef));
         end
      end
      // receiver stall pattern: long open stretches, then choppy phases
      stall_phase++;
      if (reset) rsp_tready <= 1'b0;
      else if (stall_phase[9:8] == 2'd0) rsp_tready <= 1'b1;
      else if (stall_phase[9:8] == 2'd1) rsp_tready <= stall_phase[1:0] != 2'd0;
      else rsp_tready <= $urandom_range(0, 2) != 0;
   end

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 16'h0000 | 16'($urandom_range(0, 15));
         1: return 16'($urandom_range(0, 255)) << 4 ^ 16'($urandom);
         2: return {$urandom_range(0, 1) ? 12'hfff : 12'h000, 4'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] w [0:2];
      readings_q.push_back({16'h0000, 16'h0000, 16'h0000}); // zero over zero
      readings_q.push_back({16'h000f, 16'h000f, 16'h000f}); // low nibbles only
      readings_q.push_back({16'h7fff, 16'h0000, 16'h0000}); // z only: both angles 0
      readings_q.push_back({16'h0000, 16'h0000, 16'h7fff}); // x only: pitch +90
      readings_q.push_back({16'h0000, 16'h0000, 16'h8000}); // x only: pitch -90
      readings_q.push_back({16'h0000, 16'h7fff, 16'h0000}); // y only: roll +90
      readings_q.push_back({16'h0000, 16'h8000, 16'h0000}); // y only: roll -90
      readings_q.push_back({16'h8000, 16'h8000, 16'h8000});
      readings_q.push_back({16'h7fff, 16'h7fff, 16'h7fff});
      readings_q.push_back({16'h8000, 16'h7fff, 16'h8000});
      readings_q.push_back({16'h7fff, 16'h8000, 16'h7fff});
      readings_q.push_back({16'h0010, 16'h0010, 16'h0010});
      readings_q.push_back({16'hfff0, 16'h0010, 16'hfff0});
      readings_q.push_back({16'h0000, 16'h0010, 16'h0000}); // smallest roll numerator
      readings_q.push_back({16'h0010, 16'h7ff0, 16'h0000});
      readings_q.push_back({16'h7ff0, 16'h0010, 16'h0010});
      readings_q.push_back({16'h5555, 16'haaaa, 16'h5555});
      for (int n = 0; n < 500; n++) begin
         for (int k = 0; k < 3; k++) w[k] = rand_word();
         readings_q.push_back({w[2], w[1], w[0]});
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (readings_q.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      while (angles_q.size() != 0) @(posedge clock);
      repeat (3 * atpr_pkg::LANE_LATENCY) @(posedge clock);
      if (fail_count == 0 && angles_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
